[hdl/msd_pkg.sv]
`default_nettype none

package msd_pkg;

    // sync word bytes and the image frame type code
    localparam logic [7:0] SYNC_A     = 8'hAA;
    localparam logic [7:0] SYNC_B     = 8'h55;
    localparam logic [7:0] IMAGE_TYPE = 8'h01;

    // watchdog reset value
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    // item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // store selection
    localparam logic TARGET_IMAGE = 1'b0;
    localparam logic TARGET_CMD   = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic        wr_valid;
        logic        wr_target;
        logic [9:0]  wr_addr;
        logic [7:0]  wr_data;
        logic        frame_done;
        logic [7:0]  frame_type;
        logic [15:0] frame_len;
        logic [10:0] stored_len;
        logic        timed_out;
    } result_t;

endpackage

`default_nettype wire

[hdl/msd_item_if.sv]
`default_nettype none

interface msd_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

`default_nettype wire

[hdl/msd_result_if.sv]
`default_nettype none

interface msd_result_if;
    logic        valid;
    logic        ready;
    logic        wr_valid;
    logic        wr_target;
    logic [9:0]  wr_addr;
    logic [7:0]  wr_data;
    logic        frame_done;
    logic [7:0]  frame_type;
    logic [15:0] frame_len;
    logic [10:0] stored_len;
    logic        timed_out;

    modport source (
        output valid, output wr_valid, output wr_target, output wr_addr, output wr_data,
        output frame_done, output frame_type, output frame_len, output stored_len,
        output timed_out, input ready
    );
    modport sink (
        input valid, input wr_valid, input wr_target, input wr_addr, input wr_data,
        input frame_done, input frame_type, input frame_len, input stored_len,
        input timed_out, output ready
    );
endinterface

`default_nettype wire

[hdl/msd_cfg_if.sv]
`default_nettype none

interface msd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] timeout_ticks;

    modport source (output valid, output timeout_ticks, input ready);
    modport sink (input valid, input timeout_ticks, output ready);
endinterface

`default_nettype wire

[hdl/msd_parser.sv]
`default_nettype none

module msd_parser #(
    parameter int IMAGE_BYTES = 1024,
    parameter int CMD_BYTES   = 128
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire msd_pkg::item_t   item,
    input  wire logic [15:0]      timeout_ticks,
    output msd_pkg::result_t      res
);

    // limits held one bit wider so the full 16-bit range compares cleanly
    localparam logic [16:0] IMG_LIM = 17'(IMAGE_BYTES);
    localparam logic [16:0] CMD_LIM = 17'(CMD_BYTES - 1);

    typedef enum logic [2:0] {
        PH_S1, PH_S2, PH_S3, PH_S4, PH_TYPE, PH_LENHI, PH_LENLO, PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  kind_reg, kind_next;
    logic [15:0] decl_reg, decl_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] elapsed_inc;
    logic [15:0] idx_inc;

    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign idx_inc     = idx_reg + 16'd1;

    // next state and result for the item at the input
    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        decl_next    = decl_reg;
        idx_next     = idx_reg;
        elapsed_next = elapsed_reg;
        res          = '0;

        if (item.opcode == msd_pkg::OP_TICK)
        begin
            // watchdog runs only while a frame is open
            if (phase_reg != PH_S1)
            begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc > timeout_ticks)
                begin
                    phase_next    = PH_S1;
                    res.timed_out = 1'b1;
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_S1:
                begin
                    if (item.rx_byte == msd_pkg::SYNC_A)
                    begin
                        elapsed_next = '0;
                        phase_next   = PH_S2;
                    end
                end
                PH_S2:
                begin
                    if (item.rx_byte == msd_pkg::SYNC_B)
                        phase_next = PH_S3;
                    else if (item.rx_byte != msd_pkg::SYNC_A)
                        phase_next = PH_S1;
                end
                PH_S3:
                begin
                    phase_next = (item.rx_byte == msd_pkg::SYNC_A) ? PH_S4 : PH_S1;
                end
                PH_S4:
                begin
                    if (item.rx_byte == msd_pkg::SYNC_B)
                        phase_next = PH_TYPE;
                    else if (item.rx_byte == msd_pkg::SYNC_A)
                        phase_next = PH_S2;
                    else
                        phase_next = PH_S1;
                end
                PH_TYPE:
                begin
                    kind_next  = item.rx_byte;
                    phase_next = PH_LENHI;
                end
                PH_LENHI:
                begin
                    decl_next  = {item.rx_byte, 8'h00};
                    phase_next = PH_LENLO;
                end
                PH_LENLO:
                begin
                    decl_next = {decl_reg[15:8], item.rx_byte};
                    idx_next  = '0;
                    if ({decl_reg[15:8], item.rx_byte} == 16'd0)
                    begin
                        // empty frame closes right here
                        res.frame_done = 1'b1;
                        res.frame_type = kind_reg;
                        res.frame_len  = '0;
                        phase_next     = PH_S1;
                    end
                    else
                        phase_next = PH_PAYLOAD;
                end
                default:
                begin
                    idx_next = idx_inc;
                    if (kind_reg == msd_pkg::IMAGE_TYPE)
                    begin
                        if ({1'b0, idx_reg} < IMG_LIM)
                        begin
                            res.wr_valid  = 1'b1;
                            res.wr_target = msd_pkg::TARGET_IMAGE;
                            res.wr_addr   = idx_reg[9:0];
                            res.wr_data   = item.rx_byte;
                        end
                        if (idx_inc >= decl_reg || {1'b0, idx_inc} >= IMG_LIM)
                        begin
                            res.frame_done = 1'b1;
                            res.frame_type = kind_reg;
                            res.frame_len  = decl_reg;
                            res.stored_len = idx_inc[10:0];
                            phase_next     = PH_S1;
                        end
                    end
                    else
                    begin
                        if ({1'b0, idx_reg} < CMD_LIM)
                        begin
                            res.wr_valid  = 1'b1;
                            res.wr_target = msd_pkg::TARGET_CMD;
                            res.wr_addr   = idx_reg[9:0];
                            res.wr_data   = item.rx_byte;
                        end
                        if (idx_inc >= decl_reg)
                        begin
                            res.frame_done = 1'b1;
                            res.frame_type = kind_reg;
                            res.frame_len  = decl_reg;
                            res.stored_len = ({1'b0, idx_inc} > CMD_LIM) ? CMD_LIM[10:0]
                                                                         : idx_inc[10:0];
                            phase_next     = PH_S1;
                        end
                    end
                end
            endcase
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_S1;
            kind_reg    <= '0;
            decl_reg    <= '0;
            idx_reg     <= '0;
            elapsed_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            decl_reg    <= decl_next;
            idx_reg     <= idx_next;
            elapsed_reg <= elapsed_next;
        end
    end

`ifndef SYNTHESIS
    // a tick never writes or finishes a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        step && item.opcode == msd_pkg::OP_TICK |-> !res.wr_valid && !res.frame_done)
        else $error("tick produced a write or frame end");

    // a finished or abandoned frame goes back to the hunt
    assert property (@(posedge clk) disable iff (!rst_n)
        step && (res.frame_done || res.timed_out) |=> phase_reg == PH_S1)
        else $error("frame end did not return to hunt");

    // a fresh sync start clears the watchdog count
    assert property (@(posedge clk) disable iff (!rst_n)
        step && item.opcode == msd_pkg::OP_BYTE && phase_reg == PH_S1
            && item.rx_byte == msd_pkg::SYNC_A |=> elapsed_reg == 16'd0)
        else $error("watchdog not cleared at frame start");

    // writes happen only in the payload phase
    assert property (@(posedge clk) disable iff (!rst_n)
        res.wr_valid |-> phase_reg == PH_PAYLOAD)
        else $error("store write outside payload");
`endif

endmodule

`default_nettype wire

[hdl/magic_sync_packet_deframer.sv]
`default_nettype none

// channel   dir  payload                                      transfer
// item      in   opcode, rx_byte                              valid && ready
// result    out  wr_*, frame_done, frame_type, frame_len,     valid && ready
//                stored_len, timed_out
// cfg       in   timeout_ticks                                valid && ready
//
// one item per cycle while results are taken: the frame state updates in a single pass and the
// result lands in one output register, one result per item.
// the item channel is ready whenever that output register is empty or
// being drained in the same cycle, so a stalled result holds input off.
// rst_n clears the frame state, the output valid and sets timeout to 100.
// cfg is always ready and takes effect on the next item.

module magic_sync_packet_deframer #(
    parameter int IMAGE_BYTES = 1024,
    parameter int CMD_BYTES   = 128
) (
    input wire logic     clk,
    input wire logic     rst_n,
    msd_item_if.sink     item,
    msd_result_if.source result,
    msd_cfg_if.sink      cfg
);

    logic             step;
    logic             out_valid_reg;
    logic [15:0]      timeout_reg;
    msd_pkg::item_t   cur_item;
    msd_pkg::result_t res;
    msd_pkg::result_t res_reg;

    assign item.ready = !out_valid_reg || result.ready;
    assign step       = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign cur_item.opcode  = item.opcode;
    assign cur_item.rx_byte = item.rx_byte;

    msd_parser #(
        .IMAGE_BYTES (IMAGE_BYTES),
        .CMD_BYTES   (CMD_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (cur_item),
        .timeout_ticks (timeout_reg),
        .res           (res)
    );

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= msd_pkg::TIMEOUT_RESET;
        else if (cfg.valid)
            timeout_reg <= cfg.timeout_ticks;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    assign result.valid      = out_valid_reg;
    assign result.wr_valid   = res_reg.wr_valid;
    assign result.wr_target  = res_reg.wr_target;
    assign result.wr_addr    = res_reg.wr_addr;
    assign result.wr_data    = res_reg.wr_data;
    assign result.frame_done = res_reg.frame_done;
    assign result.frame_type = res_reg.frame_type;
    assign result.frame_len  = res_reg.frame_len;
    assign result.stored_len = res_reg.stored_len;
    assign result.timed_out  = res_reg.timed_out;

endmodule

`default_nettype wire
